@@ rtl/lscd_pkg.sv @@
// ----------------------------------------------------------------------------
// lscd_pkg
// Shared types, constants and helper functions of the LED strip command decoder.
// ----------------------------------------------------------------------------
package lscd_pkg;

  localparam int unsigned MaxFields     = 4;
  localparam int unsigned FieldChars    = 16;
  localparam int unsigned NameChars     = 16;
  localparam int unsigned FastLineChars = 32;

  localparam int unsigned SlotW = $clog2(MaxFields);
  localparam int unsigned LenW  = 7;  // holds the largest length limit plus one

  localparam logic [30:0] HexMax = 31'h7FFF_FFFF;

  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChT      = 8'h54;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_NAME  = 3'd1,
    PH_PARAM = 3'd2,
    PH_BRACE = 3'd3,
    PH_NL    = 3'd4,
    PH_FA    = 3'd5,
    PH_FB    = 3'd6,
    PH_FC    = 3'd7
  } phase_e;

  typedef enum logic [3:0] {
    K_SET_ONE     = 4'd0,
    K_FILL_SPAN   = 4'd1,
    K_DELAY       = 4'd2,
    K_SET_MAX     = 4'd3,
    K_INIT        = 4'd4,
    K_UPDATE      = 4'd5,
    K_FAST_ON     = 4'd6,
    K_FAST_UPDATE = 4'd7,
    K_FAST_DELAY  = 4'd8,
    K_FAST_SET    = 4'd9,
    K_EXIT_FAST   = 4'd10,
    K_PARSE_ERR   = 4'd11,
    K_UNKNOWN     = 4'd12,
    K_RANGE_ERR   = 4'd13
  } kind_e;

  // Parser state visible to the line-end logic.
  typedef struct packed {
    logic          fast;
    phase_e        phase;
    logic [6:0]    match;
    logic [LenW-1:0] flen;
    logic          err;
  } line_st_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] pixel_index;
    logic [31:0] color;
    logic [15:0] pixel_count;
    logic [30:0] delay_ms;
  } result_t;

  // Expected character of command name i at position p; 0 past its end.
  function automatic logic [7:0] name_char(input logic [2:0] i, input logic [3:0] p);
    logic [79:0] s;
    s = '0;
    case (i)
      3'd0: s = {"SET_ONE", 24'h0};
      3'd1: s = {"SET_MANY", 16'h0};
      3'd2: s = {"DELAY", 40'h0};
      3'd3: s = {"SET_MAX", 24'h0};
      3'd4: s = {"INIT", 48'h0};
      3'd5: s = {"UPDATE", 32'h0};
      3'd6: s = "ENTER_FAST";
      default: s = '0;
    endcase
    return s[79 - 8*p -: 8];
  endfunction

  function automatic logic [3:0] name_len(input logic [2:0] i);
    logic [3:0] l;
    case (i)
      3'd0: l = 4'd7;
      3'd1: l = 4'd8;
      3'd2: l = 4'd5;
      3'd3: l = 4'd7;
      3'd4: l = 4'd4;
      3'd5: l = 4'd6;
      3'd6: l = 4'd10;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  // Returns {is_digit, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

@@ rtl/lscd_stream_if.sv @@
// ----------------------------------------------------------------------------
// lscd_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface lscd_stream_if #(parameter type T = logic [7:0]);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lscd_result_reg.sv @@
// ----------------------------------------------------------------------------
// lscd_result_reg
// Output register with a skid stage so the input side waits only when both are full.
// ----------------------------------------------------------------------------
module lscd_result_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lscd_pkg::result_t  data_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output lscd_pkg::result_t  data_o
);
  logic              out_v_q, skid_v_q;
  lscd_pkg::result_t out_q, skid_q;

  assign room_o  = !skid_v_q;
  assign valid_o = out_v_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || ready_i) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= push_i;
        end else begin
          out_v_q <= push_i;
        end
      end else if (push_i) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || ready_i) begin
      if (skid_v_q) begin
        out_q  <= skid_q;
        if (push_i) skid_q <= data_i;
      end else if (push_i) begin
        out_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end
endmodule

@@ rtl/lscd_parser.sv @@
// ----------------------------------------------------------------------------
// lscd_parser
// Per-byte parsing: name matching, hex fields and line-end result building.
// ----------------------------------------------------------------------------
module lscd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        c_i,
  output logic              push_o,
  output lscd_pkg::result_t res_o
);
  localparam int unsigned LenW = lscd_pkg::LenW;

  lscd_pkg::line_st_t st_q, st_d;
  logic [30:0] pv_q [lscd_pkg::MaxFields];
  logic [30:0] pv_d [lscd_pkg::MaxFields];
  logic [lscd_pkg::SlotW:0] pn_q, pn_d;
  logic        stop_q, stop_d;
  logic [15:0] strip_q, strip_d;

  logic [4:0]  hd;
  logic [34:0] grown;
  logic [30:0] hv;
  logic [lscd_pkg::SlotW:0] slot;
  logic        feed;
  logic [6:0]  m;
  logic [LenW-1:0] fl;
  logic [16:0] sum;
  logic [6:0]  nm;

  assign hd = lscd_pkg::hex_digit(c_i);
  assign slot = st_q.fast ? ((st_q.phase == lscd_pkg::PH_FA) ? '0
                                                              : (lscd_pkg::SlotW + 1)'(1))
                          : pn_q;
  assign grown = {pv_q[slot[lscd_pkg::SlotW-1:0]], 4'h0} + {31'h0, hd[3:0]};
  assign hv = (grown > {4'h0, lscd_pkg::HexMax}) ? lscd_pkg::HexMax : grown[30:0];
  assign sum = {1'b0, pv_q[0][15:0]} + {1'b0, pv_q[2][15:0]};

  always_comb begin
    st_d = st_q;
    pn_d = pn_q;
    stop_d = stop_q;
    strip_d = strip_q;
    pv_d = pv_q;
    push_o = 1'b0;
    res_o = '0;
    feed = 1'b0;
    m = st_q.match;
    fl = st_q.flen;
    nm = st_q.match;
    if (en_i) begin
      if (c_i == lscd_pkg::ChNl) begin
        push_o = 1'b1;
        if (st_q.fast) begin
          m = st_q.match;
          if (fl != LenW'(1)) m[0] = 1'b0;
          if (fl != LenW'(4)) m[1] = 1'b0;
          if (fl == '0) m[2] = 1'b0;
          if (fl <= LenW'(lscd_pkg::FastLineChars)) fl = fl + 1'b1;
          if (st_q.err || fl > LenW'(lscd_pkg::FastLineChars))
            res_o.kind = lscd_pkg::K_PARSE_ERR;
          else if (m[0] && fl == LenW'(2)) res_o.kind = lscd_pkg::K_FAST_UPDATE;
          else if (m[2]) begin
            if (st_q.phase == lscd_pkg::PH_FA) res_o.kind = lscd_pkg::K_PARSE_ERR;
            else begin
              res_o.kind = lscd_pkg::K_FAST_DELAY;
              res_o.delay_ms = pv_q[1];
            end
          end else if (m[1] && fl == LenW'(5)) begin
            res_o.kind = lscd_pkg::K_EXIT_FAST;
            st_d.fast = 1'b0;
          end else if (st_q.phase == lscd_pkg::PH_FA) res_o.kind = lscd_pkg::K_PARSE_ERR;
          else begin
            res_o.kind = lscd_pkg::K_FAST_SET;
            res_o.pixel_index = pv_q[0][15:0];
            res_o.color = {1'b0, pv_q[1]};
          end
        end else if (st_q.err || st_q.phase != lscd_pkg::PH_NL) begin
          res_o.kind = lscd_pkg::K_PARSE_ERR;
        end else begin
          case (st_q.match)
            7'h01: begin
              res_o.kind = lscd_pkg::K_SET_ONE;
              res_o.pixel_index = pv_q[0][15:0];
              res_o.color = {1'b0, pv_q[1]};
            end
            7'h02: begin
              res_o.kind = (sum > {1'b0, strip_q}) ? lscd_pkg::K_RANGE_ERR
                                                   : lscd_pkg::K_FILL_SPAN;
              res_o.pixel_index = pv_q[0][15:0];
              res_o.color = {1'b0, pv_q[1]};
              res_o.pixel_count = pv_q[2][15:0];
            end
            7'h04: begin
              res_o.kind = lscd_pkg::K_DELAY;
              res_o.delay_ms = pv_q[0];
            end
            7'h08: begin
              res_o.kind = lscd_pkg::K_SET_MAX;
              res_o.pixel_index = pv_q[0][15:0];
              strip_d = pv_q[0][15:0];
            end
            7'h10: begin
              res_o.kind = lscd_pkg::K_INIT;
              res_o.pixel_index = pv_q[0][15:0];
              res_o.color = {1'b0, pv_q[1]};
              strip_d = pv_q[0][15:0];
            end
            7'h20: res_o.kind = lscd_pkg::K_UPDATE;
            7'h40: begin
              res_o.kind = lscd_pkg::K_FAST_ON;
              st_d.fast = 1'b1;
            end
            default: res_o.kind = lscd_pkg::K_UNKNOWN;
          endcase
        end
        // Start a fresh line.
        st_d.phase = st_d.fast ? lscd_pkg::PH_FA : lscd_pkg::PH_START;
        st_d.match = 7'h7F;
        st_d.flen = '0;
        st_d.err = 1'b0;
        pn_d = '0;
        stop_d = 1'b0;
        for (int i = 0; i < int'(lscd_pkg::MaxFields); i++) pv_d[i] = '0;
      end else if (st_q.fast) begin
        if (c_i != 8'h00 && !st_q.err) begin
          if (fl >= LenW'(2) || c_i != (fl == '0 ? 8'h55 : lscd_pkg::ChNl)) m[0] = 1'b0;
          if (fl >= LenW'(5) || c_i != (fl == LenW'(0) ? 8'h45 : fl == LenW'(1) ? 8'h58 :
              fl == LenW'(2) ? 8'h49 : fl == LenW'(3) ? 8'h54 : lscd_pkg::ChNl)) m[1] = 1'b0;
          if (fl == '0 && c_i != lscd_pkg::ChT) m[2] = 1'b0;
          if (fl <= LenW'(lscd_pkg::FastLineChars)) fl = fl + 1'b1;
          st_d.match = m;
          st_d.flen = fl;
          if (st_q.phase == lscd_pkg::PH_FA) begin
            if (c_i == lscd_pkg::ChColon) begin
              st_d.phase = lscd_pkg::PH_FB;
              stop_d = 1'b0;
            end else feed = 1'b1;
          end else if (st_q.phase == lscd_pkg::PH_FB) begin
            if (c_i == lscd_pkg::ChColon) st_d.phase = lscd_pkg::PH_FC;
            else feed = 1'b1;
          end
        end
      end else if (!st_q.err) begin
        case (st_q.phase)
          lscd_pkg::PH_START: begin
            if (c_i == lscd_pkg::ChLBrace) st_d.phase = lscd_pkg::PH_NAME;
            else st_d.err = 1'b1;
          end
          lscd_pkg::PH_NAME: begin
            if (c_i == lscd_pkg::ChColon || c_i == lscd_pkg::ChRBrace) begin
              for (int i = 0; i < 7; i++)
                if ({3'h0, lscd_pkg::name_len(3'(i))} != fl) nm[i] = 1'b0;
              st_d.match = nm;
              st_d.flen = '0;
              st_d.phase = (c_i == lscd_pkg::ChColon) ? lscd_pkg::PH_PARAM
                                                      : lscd_pkg::PH_NL;
            end else if (fl >= LenW'(lscd_pkg::NameChars)) begin
              st_d.err = 1'b1;
            end else begin
              for (int i = 0; i < 7; i++)
                if (fl >= LenW'(lscd_pkg::name_len(3'(i))) ||
                    lscd_pkg::name_char(3'(i), fl[3:0]) != c_i) nm[i] = 1'b0;
              st_d.match = nm;
              st_d.flen = fl + 1'b1;
            end
          end
          lscd_pkg::PH_PARAM: begin
            if (c_i == lscd_pkg::ChComma) begin
              if (pn_q + 1'b1 >= (lscd_pkg::SlotW + 1)'(lscd_pkg::MaxFields))
                st_d.phase = lscd_pkg::PH_BRACE;
              else begin
                pn_d = pn_q + 1'b1;
                st_d.flen = '0;
                stop_d = 1'b0;
              end
            end else if (c_i == lscd_pkg::ChRBrace) begin
              st_d.phase = lscd_pkg::PH_NL;
            end else if (fl >= LenW'(lscd_pkg::FieldChars)) begin
              st_d.err = 1'b1;
            end else begin
              st_d.flen = fl + 1'b1;
              feed = 1'b1;
            end
          end
          lscd_pkg::PH_BRACE: begin
            if (c_i == lscd_pkg::ChRBrace) st_d.phase = lscd_pkg::PH_NL;
            else st_d.err = 1'b1;
          end
          default: st_d.err = 1'b1;
        endcase
      end
      if (feed && !stop_q) begin
        if (hd[4]) pv_d[slot[lscd_pkg::SlotW-1:0]] = hv;
        else stop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{fast: 1'b0, phase: lscd_pkg::PH_START, match: 7'h7F, flen: '0, err: 1'b0};
      pn_q <= '0;
      stop_q <= 1'b0;
      strip_q <= '0;
      for (int i = 0; i < int'(lscd_pkg::MaxFields); i++) pv_q[i] <= '0;
    end else begin
      st_q <= st_d;
      pn_q <= pn_d;
      stop_q <= stop_d;
      strip_q <= strip_d;
      pv_q <= pv_d;
    end
  end
endmodule

@@ rtl/led_strip_command_decoder.sv @@
// ----------------------------------------------------------------------------
// led_strip_command_decoder
// Decodes newline-terminated LED strip text commands, one byte per cycle while the output stage has room.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_if    | in  | rx_byte
//  out_if   | out | kind, pixel_index, color, pixel_count, delay_ms
//
// A byte is taken every cycle while the output stage has room; a newline's result
// is registered in the output entry, or in the skid entry while the output is held.
// A two-entry output stage lets bytes flow while a result waits; input stalls
// only when both entries are full. Reset returns to normal mode, strip length 0.
module led_strip_command_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  lscd_stream_if.sink   in_if,
  lscd_stream_if.source out_if
);
  logic              push, room, acc;
  lscd_pkg::result_t res, odata;

  assign in_if.ready = room;
  assign acc = in_if.valid && room;

  lscd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (acc),
    .c_i    (in_if.data[7:0]),
    .push_o (push),
    .res_o  (res)
  );

  lscd_result_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .room_o  (room),
    .valid_o (out_if.valid),
    .ready_i (out_if.ready),
    .data_o  (odata)
  );

  assign out_if.data = odata;

  a_push_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (in_if.data[7:0] == lscd_pkg::ChNl))
    else $error("result pushed without newline");
  a_kind_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (odata.kind <= 4'd13))
    else $error("result kind out of range");
  a_push_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_if.valid)
    else $error("pushed result not visible");
endmodule
